>>> src/sync_header_checksum_frame_receiver_top_assert.svh
// Assertion macros for the frame receiver.
`ifndef SYNC_HEADER_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_HEADER_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHFR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHFR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/shfr_pkg.sv
// Types and constants shared by the frame receiver modules.
`timescale 1ns / 1ps
package shfr_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h55;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_GOOD    = 3'd1;
   localparam logic [2:0] ST_CSUM    = 3'd2;
   localparam logic [2:0] ST_HDR     = 3'd3;
   localparam logic [2:0] ST_TIMEOUT = 3'd4;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 2'd2;

   localparam logic [7:0] RST_HEADER_FIRST  = 8'h81;
   localparam logic [7:0] RST_HEADER_SECOND = 8'h42;
   localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd5;

   // Header byte positions while the header is collected
   localparam logic [15:0] HB_FIRST   = 16'd0;
   localparam logic [15:0] HB_SECOND  = 16'd1;
   localparam logic [15:0] HB_SUM_LO  = 16'd2;
   localparam logic [15:0] HB_SUM_HI  = 16'd3;
   localparam logic [15:0] HB_LEN_LO  = 16'd4;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] timeout_ticks;
   } shfr_cfg_type;

   typedef struct packed {
      logic        sync_seen;
      logic        in_frame;
      logic        header_done;
      logic [15:0] byte_count;
      logic [15:0] running_sum;
      logic [15:0] expected_sum;
      logic [15:0] expected_length;
      logic [8:0]  elapsed_ticks;
   } shfr_state_type;

   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [2:0]  frame_status;
      logic [15:0] frame_length;
   } shfr_result_type;

endpackage

>>> src/shfr_if.sv
// Item channel interfaces: received bytes/ticks in, payload and status out.
`timescale 1ns / 1ps
interface shfr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface shfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [15:0] payload_index;
   logic [2:0]  frame_status;
   logic [15:0] frame_length;

   modport source (output valid, output payload_valid, output payload_byte,
                   output payload_index, output frame_status, output frame_length,
                   input ready);
   modport sink   (input valid, input payload_valid, input payload_byte,
                   input payload_index, input frame_status, input frame_length,
                   output ready);
endinterface

>>> src/shfr_csr.sv
// Configuration registers of the frame receiver.
`timescale 1ns / 1ps
module shfr_csr
   import shfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output shfr_cfg_type           cfg
);

   shfr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  cfg_in.header_first  = csr_wdata;
            CSR_HEADER_SECOND: cfg_in.header_second = csr_wdata;
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first  <= RST_HEADER_FIRST;
         cfg_ff.header_second <= RST_HEADER_SECOND;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/shfr_step.sv
// Per-item frame parser: next state and result for one byte or tick.
`timescale 1ns / 1ps
module shfr_step
   import shfr_pkg::*;
(
   input  shfr_cfg_type    cfg,
   input  shfr_state_type  cur,
   input  logic            opcode,
   input  logic [7:0]      rx_byte,
   output shfr_state_type  nxt,
   output shfr_result_type res
);

   always_comb begin
      nxt = cur;
      res = '0;
      res.frame_status = ST_NONE;
      if (opcode == OP_TICK) begin
         if (cur.in_frame) begin
            if (cur.elapsed_ticks != '1) begin
               nxt.elapsed_ticks = cur.elapsed_ticks + 9'd1;
            end
            if (nxt.elapsed_ticks > {1'b0, cfg.timeout_ticks}) begin
               nxt = '0;
               res.frame_status = ST_TIMEOUT;
            end
         end
      end else begin
         // extra sync bytes are skipped until the first header byte
         if (!cur.sync_seen) begin
            if (rx_byte == SYNC_BYTE) begin
               nxt.sync_seen = 1'b1;
            end
         end else if (!cur.in_frame) begin
            if (rx_byte != SYNC_BYTE) begin
               nxt.in_frame      = 1'b1;
               nxt.byte_count    = '0;
               nxt.elapsed_ticks = '0;
            end
         end

         if (nxt.in_frame) begin
            if (!nxt.header_done) begin
               if (nxt.byte_count == HB_FIRST || nxt.byte_count == HB_SECOND) begin
                  if (rx_byte != ((nxt.byte_count == HB_FIRST) ? cfg.header_first
                                                               : cfg.header_second)) begin
                     nxt = '0;
                     res.frame_status = ST_HDR;
                  end else begin
                     nxt.byte_count = nxt.byte_count + 16'd1;
                  end
               end else if (nxt.byte_count == HB_SUM_LO) begin
                  nxt.expected_sum[7:0] = rx_byte;
                  nxt.byte_count        = HB_SUM_HI;
               end else if (nxt.byte_count == HB_SUM_HI) begin
                  nxt.expected_sum[15:8] = rx_byte;
                  nxt.byte_count         = HB_LEN_LO;
               end else if (nxt.byte_count == HB_LEN_LO) begin
                  nxt.expected_length[7:0] = rx_byte;
                  nxt.byte_count           = HB_LEN_LO + 16'd1;
               end else begin
                  nxt.expected_length[15:8] = rx_byte;
                  nxt.header_done           = 1'b1;
                  nxt.byte_count            = '0;
                  nxt.running_sum           = '0;
                  if (nxt.expected_length == 16'd0) begin
                     nxt = '0;
                     res.frame_status = ST_GOOD;
                  end
               end
            end else begin
               res.payload_valid = 1'b1;
               res.payload_byte  = rx_byte;
               res.payload_index = nxt.byte_count;
               nxt.running_sum   = nxt.running_sum + {8'd0, rx_byte};
               nxt.byte_count    = nxt.byte_count + 16'd1;
               if (nxt.byte_count >= nxt.expected_length) begin
                  if (nxt.running_sum == nxt.expected_sum) begin
                     res.frame_status = ST_GOOD;
                     res.frame_length = nxt.expected_length;
                  end else begin
                     res.frame_status = ST_CSUM;
                  end
                  nxt = '0;
               end
            end
         end
      end
   end

endmodule

>>> src/shfr_rsp_buf.sv
// Result register between the parser and the result channel.
`timescale 1ns / 1ps
module shfr_rsp_buf
   import shfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  shfr_result_type res,
   output logic            can_load,
   shfr_rsp_if.source      rsp_chan
);

   logic            valid_ff, valid_in;
   shfr_result_type data_ff;

   // a new result may enter when the slot is empty or drains this cycle
   assign can_load = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.payload_valid = data_ff.payload_valid;
   assign rsp_chan.payload_byte  = data_ff.payload_byte;
   assign rsp_chan.payload_index = data_ff.payload_index;
   assign rsp_chan.frame_status  = data_ff.frame_status;
   assign rsp_chan.frame_length  = data_ff.frame_length;

endmodule

>>> src/sync_header_checksum_frame_receiver_top.sv
// Top level of the sync/header/checksum frame receiver.
`timescale 1ns / 1ps
`include "sync_header_checksum_frame_receiver_top_assert.svh"
// Takes one item (a received byte or a 1 ms tick) per clock and returns exactly one
// result item for it in the next cycle from a single result register; the parser state
// (sync, header position, running sum, tick count) updates in the same cycle the item
// is accepted. Sustained rate is one item per cycle, limited only by the result
// register draining: req_chan.ready is low only while a result is held and
// rsp_chan.ready is low. Payload bytes come out with their index; the last payload
// byte carries the good/checksum-error status, and header mismatch or timeout
// abandon the frame. Registers must be written through csr_we/csr_index/csr_wdata
// only while the block is idle; the block itself does not enforce this.
module sync_header_checksum_frame_receiver_top
   import shfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   shfr_req_if.sink               req_chan,
   shfr_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   shfr_cfg_type    cfg;
   shfr_state_type  state_ff, state_in;
   shfr_result_type res;
   logic            can_load;
   logic            accept;

   shfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   shfr_step u_step (
      .cfg     (cfg),
      .cur     (state_ff),
      .opcode  (req_chan.opcode),
      .rx_byte (req_chan.rx_byte),
      .nxt     (state_in),
      .res     (res)
   );

   shfr_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .res      (res),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   `SHFR_ASSERT_IMP(a_hdr_in_frame, clock, reset, state_ff.header_done, state_ff.in_frame && state_ff.sync_seen, "header_done without open frame")
   `SHFR_ASSERT_IMP(a_len_only_good, clock, reset, rsp_chan.valid && rsp_chan.frame_status != ST_GOOD, rsp_chan.frame_length == 16'd0, "frame_length set without good status")
   `SHFR_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready, "item taken while result stalled")
   `SHFR_ASSERT_NXT(a_accept_rsp, clock, reset, accept, rsp_chan.valid, "accepted item produced no result")

endmodule
